// ===== rtl/kmce_pkg.sv =====
`timescale 1ns / 1ps

package kmce_pkg;

  // Matrix geometry and line list defaults
  localparam int unsigned KMCE_ROWS     = 8;
  localparam int unsigned KMCE_COLS     = 8;
  localparam int unsigned KMCE_LIST_LEN = 8;

  // Fixed field widths
  localparam int unsigned LINE_W     = 4;
  localparam int unsigned POS_W      = 3;
  localparam int unsigned MAP_W      = 16;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LIST_W     = 32;
  localparam int unsigned LIST_SLOTS = 8;
  localparam int unsigned CFG_IDX_W  = 4;

  // Line number that marks an unused list entry
  localparam logic [LINE_W-1:0] NONE_LINE = 4'hf;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_LINES = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_LINES  = 4'd1;

  localparam logic [LIST_W-1:0] LIST_RESET = 32'hffff_ffff;

  // Event kinds
  localparam logic KIND_DOWN = 1'b0;
  localparam logic KIND_UP   = 1'b1;

  typedef struct packed {
    logic              scan_valid;
    logic [LINE_W-1:0] key_count;
    logic [LINE_W-1:0] single_row;
    logic [LINE_W-1:0] single_col;
    logic [MAP_W-1:0]  pair_map_0;
    logic [MAP_W-1:0]  pair_map_1;
    logic [MAP_W-1:0]  pair_map_2;
    logic [MAP_W-1:0]  pair_map_3;
  } scan_t;

  typedef struct packed {
    logic              event_kind;
    logic [POS_W-1:0]  scan_row;
    logic [POS_W-1:0]  scan_col;
    logic [LINE_W-1:0] index_by_col;
    logic [LINE_W-1:0] index_by_row;
    logic              last;
  } event_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [LIST_W-1:0]    data;
  } cfg_t;

  // Count used entries ahead of the first entry that matches the line
  function automatic logic [LINE_W-1:0] line_index(logic [LIST_W-1:0] list,
                                                   logic [LINE_W-1:0] line,
                                                   int unsigned       len);
    logic [LINE_W-1:0] cnt;
    logic              hit;
    logic [LINE_W-1:0] v;
    cnt = '0;
    hit = 1'b0;
    for (int e = 0; e < LIST_SLOTS; e++) begin
      v = list[e*LINE_W +: LINE_W];
      if ((e < len) && !hit) begin
        if (v == line) begin
          hit = 1'b1;
        end else if (v != NONE_LINE) begin
          cnt = cnt + 4'd1;
        end
      end
    end
    return cnt;
  endfunction

endpackage

// ===== rtl/kmce_if.sv =====
`timescale 1ns / 1ps

interface kmce_scan_if;
  import kmce_pkg::*;
  logic  valid;
  logic  ready;
  scan_t req;
  modport source (output valid, output req, input ready);
  modport sink   (input valid, input req, output ready);
endinterface

interface kmce_event_if;
  import kmce_pkg::*;
  logic   valid;
  logic   ready;
  event_t req;
  modport source (output valid, output req, input ready);
  modport sink   (input valid, input req, output ready);
endinterface

interface kmce_cfg_if;
  import kmce_pkg::*;
  logic valid;
  logic ready;
  cfg_t req;
  modport source (output valid, output req, input ready);
  modport sink   (input valid, input req, output ready);
endinterface

// ===== rtl/keypad_matrix_change_events_core.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Modport  Request
// scan_i   in   sink     scan_t: one keypad scan snapshot
// event_o  out  source   event_t: one key down or key up event
// cfg_i    in   sink     cfg_t: line list write, index 0 out lines, 1 in lines
//
// A scan is taken whenever the two-entry change queue has room.
// The back loads a change mask, then walks it at one matrix position a cycle
// while the event output is not stalled, and stops after the last changed one.
// Reset clears the pressed matrix and sets both line lists to all unused.
// A stalled event output holds the walk; the front stalls only on a full queue.

module keypad_matrix_change_events_core
  import kmce_pkg::*;
#(
  parameter int unsigned ROWS     = KMCE_ROWS,
  parameter int unsigned COLS     = KMCE_COLS,
  parameter int unsigned LIST_LEN = KMCE_LIST_LEN
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  kmce_scan_if.sink    scan_i,
  kmce_cfg_if.sink     cfg_i,
  kmce_event_if.source event_o
);

  localparam int unsigned N = ROWS * COLS;

  logic           push, push_ready, pop, pop_valid;
  logic [N-1:0]   diff, prev;
  logic [2*N-1:0] pop_data;

  kmce_front #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .scan_i       (scan_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .diff_o       (diff),
    .prev_o       (prev)
  );

  kmce_queue #(
    .WIDTH (2 * N)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_data_i  ({diff, prev}),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_data_o   (pop_data)
  );

  kmce_back #(
    .ROWS     (ROWS),
    .COLS     (COLS),
    .LIST_LEN (LIST_LEN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_i),
    .event_o     (event_o),
    .pop_valid_i (pop_valid),
    .pop_o       (pop),
    .diff_i      (pop_data[2*N-1:N]),
    .prev_i      (pop_data[N-1:0])
  );

endmodule

// ===== rtl/kmce_front.sv =====
`timescale 1ns / 1ps

module kmce_front
  import kmce_pkg::*;
#(
  parameter int unsigned ROWS = KMCE_ROWS,
  parameter int unsigned COLS = KMCE_COLS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  kmce_scan_if.sink            scan_i,
  output logic                 push_o,
  input  logic                 push_ready_i,
  output logic [ROWS*COLS-1:0] diff_o,
  output logic [ROWS*COLS-1:0] prev_o
);

  localparam int unsigned N = ROWS * COLS;

  logic [N-1:0]         matrix_q, matrix_d;
  logic [N-1:0]         next_map;
  logic [4*MAP_W-1:0]   maps;
  logic                 accept;

  assign maps = {scan_i.req.pair_map_3, scan_i.req.pair_map_2,
                 scan_i.req.pair_map_1, scan_i.req.pair_map_0};

  // Build the new pressed matrix from the request
  always_comb begin
    next_map = '0;
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        if (scan_i.req.key_count == 4'd1) begin
          next_map[r*COLS+c] = (scan_i.req.single_row == 4'(r)) &&
                               (scan_i.req.single_col == 4'(c));
        end else if (scan_i.req.key_count > 4'd1) begin
          next_map[r*COLS+c] = maps[c*BYTE_W + r];
        end
      end
    end
  end

  assign scan_i.ready = push_ready_i;
  assign accept       = scan_i.valid && scan_i.ready;

  assign diff_o = next_map ^ matrix_q;
  assign prev_o = matrix_q;

  // Push only scans that change something; a timed-out scan clears silently
  assign push_o = accept && scan_i.req.scan_valid && (diff_o != '0);

  always_comb begin
    matrix_d = matrix_q;
    if (accept) begin
      matrix_d = scan_i.req.scan_valid ? next_map : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matrix_q <= '0;
    end else begin
      matrix_q <= matrix_d;
    end
  end

endmodule

// ===== rtl/kmce_queue.sv =====
`timescale 1ns / 1ps

module kmce_queue
  import kmce_pkg::*;
#(
  parameter int unsigned WIDTH = 2 * KMCE_ROWS * KMCE_COLS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned DEPTH = 2;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             do_push, do_pop;

  assign push_ready_o = (count_q != 2'(DEPTH));
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];

  assign do_push = push_i && push_ready_o;
  assign do_pop  = pop_i && pop_valid_o;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/kmce_back.sv =====
`timescale 1ns / 1ps

module kmce_back
  import kmce_pkg::*;
#(
  parameter int unsigned ROWS     = KMCE_ROWS,
  parameter int unsigned COLS     = KMCE_COLS,
  parameter int unsigned LIST_LEN = KMCE_LIST_LEN
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  kmce_cfg_if.sink             cfg_i,
  kmce_event_if.source         event_o,
  input  logic                 pop_valid_i,
  output logic                 pop_o,
  input  logic [ROWS*COLS-1:0] diff_i,
  input  logic [ROWS*COLS-1:0] prev_i
);

  localparam int unsigned N = ROWS * COLS;

  logic [LIST_W-1:0] out_lines_q, in_lines_q;
  logic              active_q, active_d;
  logic [N-1:0]      rem_q, rem_d;
  logic [N-1:0]      prv_q, prv_d;
  logic [N-1:0]      rem_next;
  logic [POS_W-1:0]  row_q, row_d;
  logic [POS_W-1:0]  col_q, col_d;
  logic              out_valid_q, out_valid_d;
  event_t            out_q, out_d;
  logic              can_emit;
  logic              step;

  // Line list registers, always ready
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_lines_q <= LIST_RESET;
      in_lines_q  <= LIST_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.req.index)
        CFG_OUT_LINES: out_lines_q <= cfg_i.req.data;
        CFG_IN_LINES:  in_lines_q  <= cfg_i.req.data;
        default: ;
      endcase
    end
  end

  assign rem_next = rem_q >> 1;
  assign can_emit = !out_valid_q || event_o.ready;
  // A position is done unless it changed and the output is still held
  assign step     = active_q && (!rem_q[0] || can_emit);
  assign pop_o    = !active_q && pop_valid_i;

  // Walk the changes row-major, one position a cycle unless stalled
  always_comb begin
    active_d    = active_q;
    rem_d       = rem_q;
    prv_d       = prv_q;
    row_d       = row_q;
    col_d       = col_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && event_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (pop_o) begin
      active_d = 1'b1;
      rem_d    = diff_i;
      prv_d    = prev_i;
      row_d    = '0;
      col_d    = '0;
    end else if (step) begin
      if (rem_q[0]) begin
        out_d.event_kind   = prv_q[0] ? KIND_UP : KIND_DOWN;
        out_d.scan_row     = row_q;
        out_d.scan_col     = col_q;
        out_d.index_by_col = line_index(out_lines_q, {1'b0, col_q}, LIST_LEN);
        out_d.index_by_row = line_index(in_lines_q, {1'b0, row_q}, LIST_LEN);
        out_d.last         = (rem_next == '0);
        out_valid_d        = 1'b1;
      end
      rem_d = rem_next;
      prv_d = prv_q >> 1;
      if (col_q == 3'(COLS - 1)) begin
        col_d = '0;
        row_d = row_q + 3'd1;
      end else begin
        col_d = col_q + 3'd1;
      end
      if (rem_next == '0) begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold walk state and the output request
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    prv_q <= prv_d;
    row_q <= row_d;
    col_q <= col_d;
    out_q <= out_d;
  end

  assign event_o.valid = out_valid_q;
  assign event_o.req   = out_q;

endmodule

// ===== tb/keypad_matrix_change_events_core_test.sv =====
`timescale 1ns / 1ps

module keypad_matrix_change_events_core_test;
  import kmce_pkg::*;

  localparam int unsigned HALF_PERIOD    = 5;
  localparam int unsigned RESET_CYCLES   = 12;
  localparam int unsigned IDLE_PERCENT   = 11;
  // Quiet margin after the last event before the line lists change
  localparam int unsigned SETTLE_CYCLES  = 160;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 5000;

  logic clk_i;
  logic rst_ni;

  kmce_scan_if  scan_if ();
  kmce_cfg_if   cfg_if ();
  kmce_event_if event_if ();

  keypad_matrix_change_events_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .scan_i  (scan_if),
    .cfg_i   (cfg_if),
    .event_o (event_if)
  );

  // Predictor copy of the pressed keys and the two line lists
  logic [63:0]        held_keys;
  logic [LIST_W-1:0]  col_lines;
  logic [LIST_W-1:0]  row_lines;
  event_t             pending_key_events[$];

  int   failures;
  int   scans_sent;
  int   list_writes;
  int   downs_seen;
  int   ups_seen;
  int   idle_cycles;
  logic gaps_on;
  logic stall_on;
  logic hold_req;

  always #HALF_PERIOD clk_i = ~clk_i;

  // Count used list entries ahead of the first one naming this line
  function automatic logic [LINE_W-1:0] lines_ahead(logic [LIST_W-1:0] list,
                                                    logic [POS_W-1:0]  line);
    logic [LINE_W-1:0] n;
    logic              found;
    n     = '0;
    found = 1'b0;
    for (int e = 0; e < LIST_SLOTS; e++) begin
      if (!found) begin
        if (list[e*LINE_W +: LINE_W] == LINE_W'(line)) begin
          found = 1'b1;
        end else if (list[e*LINE_W +: LINE_W] != NONE_LINE) begin
          n = n + 4'd1;
        end
      end
    end
    return n;
  endfunction

  // Build the new key matrix and queue one event per changed key; a timed-out scan clears it
  function automatic void predict_key_changes(scan_t s);
    logic [63:0] next_keys;
    logic [63:0] maps;
    event_t      changes[$];
    event_t      ev;
    next_keys = '0;
    maps      = {s.pair_map_3, s.pair_map_2, s.pair_map_1, s.pair_map_0};
    if (!s.scan_valid) begin
      held_keys = '0;
      return;
    end
    if (s.key_count == 4'd1) begin
      if (s.single_row < KMCE_ROWS && s.single_col < KMCE_COLS) begin
        next_keys[s.single_row*8 + s.single_col] = 1'b1;
      end
    end else if (s.key_count > 4'd1) begin
      for (int c = 0; c < 8; c++) begin
        for (int r = 0; r < 8; r++) begin
          next_keys[r*8 + c] = maps[c*8 + r];
        end
      end
    end
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < 8; c++) begin
        if (held_keys[r*8 + c] != next_keys[r*8 + c]) begin
          ev.event_kind   = held_keys[r*8 + c] ? KIND_UP : KIND_DOWN;
          ev.scan_row     = POS_W'(r);
          ev.scan_col     = POS_W'(c);
          ev.index_by_col = lines_ahead(col_lines, POS_W'(c));
          ev.index_by_row = lines_ahead(row_lines, POS_W'(r));
          ev.last         = 1'b0;
          changes.push_back(ev);
        end
      end
    end
    held_keys = next_keys;
    foreach (changes[i]) begin
      ev      = changes[i];
      ev.last = (i == changes.size() - 1);
      pending_key_events.push_back(ev);
    end
  endfunction

  function automatic scan_t make_scan(logic v, logic [3:0] cnt, logic [3:0] row,
                                      logic [3:0] col, logic [63:0] maps);
    scan_t s;
    s.scan_valid = v;
    s.key_count  = cnt;
    s.single_row = row;
    s.single_col = col;
    s.pair_map_0 = maps[15:0];
    s.pair_map_1 = maps[31:16];
    s.pair_map_2 = maps[47:32];
    s.pair_map_3 = maps[63:48];
    return s;
  endfunction

  // Mostly valid scans; some small edits of the held keys, some wide changes
  function automatic scan_t random_scan();
    logic [63:0] maps;
    logic [3:0]  cnt;
    logic [3:0]  row;
    logic [3:0]  col;
    logic        v;
    v    = ($urandom_range(99) >= 8);
    row  = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(7));
    col  = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(7));
    maps = '0;
    case ($urandom_range(9))
      0:       cnt = 4'd0;
      1, 2, 3: cnt = 4'd1;
      default: cnt = 4'($urandom_range(15, 2));
    endcase
    case ($urandom_range(4))
      0: maps = {$urandom, $urandom};
      1: maps = {$urandom, $urandom} & {$urandom, $urandom};
      2, 3: begin
        for (int c = 0; c < 8; c++) begin
          for (int r = 0; r < 8; r++) begin
            maps[c*8 + r] = held_keys[r*8 + c];
          end
        end
        maps = maps ^ ({$urandom, $urandom} & {$urandom, $urandom} &
                       {$urandom, $urandom});
      end
      default: maps = ($urandom_range(1) == 1) ? '1 : {$urandom, $urandom};
    endcase
    return make_scan(v, cnt, row, col, maps);
  endfunction

  // Offer one scan request, with random gaps ahead of it
  task automatic send_scan(scan_t s);
    @(negedge clk_i);
    while (gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
      scan_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    scan_if.valid <= 1'b1;
    scan_if.req   <= s;
    do @(posedge clk_i); while (!scan_if.ready);
    predict_key_changes(s);
    scans_sent++;
  endtask

  task automatic write_lines(logic [CFG_IDX_W-1:0] idx, logic [LIST_W-1:0] data);
    @(negedge clk_i);
    cfg_if.valid    <= 1'b1;
    cfg_if.req      <= '{index: idx, data: data};
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == CFG_OUT_LINES) begin
      col_lines = data;
    end else begin
      row_lines = data;
    end
    list_writes++;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Drop the scan request, drain every expected event, then let the walk finish
  task automatic wait_idle();
    @(negedge clk_i);
    scan_if.valid <= 1'b0;
    while (pending_key_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_directed_scans();
    send_scan(make_scan(1'b1, 4'd2, 4'd0, 4'd0, '1));
    send_scan(make_scan(1'b1, 4'd2, 4'd15, 4'd15, '1));
    send_scan(make_scan(1'b1, 4'd0, 4'd3, 4'd3, '1));
    send_scan(make_scan(1'b1, 4'd1, 4'd3, 4'd5, '0));
    send_scan(make_scan(1'b1, 4'd1, 4'd15, 4'd5, '1));
    send_scan(make_scan(1'b1, 4'd1, 4'd0, 4'd0, '0));
    send_scan(make_scan(1'b1, 4'd1, 4'd0, 4'd15, '0));
    send_scan(make_scan(1'b1, 4'd1, 4'd7, 4'd7, '0));
    // Keys outside the matrix are dropped
    send_scan(make_scan(1'b1, 4'd1, 4'd8, 4'd2, '0));
    send_scan(make_scan(1'b1, 4'd1, 4'd2, 4'd9, '0));
    send_scan(make_scan(1'b1, 4'd1, 4'd15, 4'd15, '0));
    send_scan(make_scan(1'b1, 4'd15, 4'd1, 4'd1, 64'h4080_1020_0408_0102));
    // A timed out scan clears the keys without any event
    send_scan(make_scan(1'b0, 4'd2, 4'd0, 4'd0, '1));
    send_scan(make_scan(1'b1, 4'd2, 4'd0, 4'd0, 64'h8001_8001_8001_8001));
    send_scan(make_scan(1'b0, 4'd0, 4'd15, 4'd15, '0));
    send_scan(make_scan(1'b1, 4'd1, 4'd7, 4'd0, 64'h1234_5678_9abc_def0));
    send_scan(make_scan(1'b1, 4'd3, 4'd0, 4'd0, 64'hff00_ff00_ff00_ff00));
    send_scan(make_scan(1'b1, 4'd0, 4'd0, 4'd0, '1));
  endtask

  // Walk both line lists through extreme and random settings
  task automatic test_line_lists();
    logic [LIST_W-1:0] col_set[$];
    logic [LIST_W-1:0] row_set[$];
    col_set = '{32'h0000_0000, 32'hffff_ffff, 32'h7654_3210, 32'hf7f5_f3f1,
                32'h3f3f_1f0f, $urandom, $urandom | 32'hf00f_0f00};
    row_set = '{32'hffff_ffff, 32'h0000_0000, 32'h0123_4567, 32'h89ab_cdef,
                32'h7777_f6f6, $urandom, $urandom & 32'h7777_7777};
    foreach (col_set[k]) begin
      wait_idle();
      write_lines(CFG_OUT_LINES, col_set[k]);
      write_lines(CFG_IN_LINES, row_set[k]);
      repeat (12) send_scan(random_scan());
    end
  endtask

  task automatic test_steady_traffic();
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    repeat (60) send_scan(random_scan());
    gaps_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  // Hold the event side while full key swings pile up behind it
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 24; i++) begin
      send_scan(make_scan(1'b1, (i % 2 == 0) ? 4'd2 : 4'd0, 4'd0, 4'd0,
                          (i % 4 == 0) ? '1 : {$urandom, $urandom}));
    end
  endtask

  task automatic test_random_scans();
    wait_idle();
    write_lines(CFG_OUT_LINES, $urandom);
    write_lines(CFG_IN_LINES, $urandom & 32'h7f7f_7f7f);
    repeat (220) send_scan(random_scan());
  endtask

  // Event side ready: random stalls, or one long hold counted here
  initial begin
    event_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        event_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        event_if.ready <= rst_ni && !(stall_on && $urandom_range(99) < IDLE_PERCENT);
      end
    end
  end

  // Compare each event against the oldest expectation
  always @(posedge clk_i) begin
    event_t want;
    event_t got;
    if (rst_ni && event_if.valid && event_if.ready) begin
      got = event_if.req;
      if (pending_key_events.size() == 0) begin
        $error("unexpected event row %0d col %0d kind %0d",
               got.scan_row, got.scan_col, got.event_kind);
        failures++;
      end else begin
        want = pending_key_events.pop_front();
        if (got.event_kind != want.event_kind) begin
          $error("event_kind expected %0d got %0d", want.event_kind, got.event_kind);
          failures++;
        end
        if (got.scan_row != want.scan_row) begin
          $error("scan_row expected %0d got %0d", want.scan_row, got.scan_row);
          failures++;
        end
        if (got.scan_col != want.scan_col) begin
          $error("scan_col expected %0d got %0d", want.scan_col, got.scan_col);
          failures++;
        end
        if (got.index_by_col != want.index_by_col) begin
          $error("index_by_col expected %0d got %0d", want.index_by_col,
                 got.index_by_col);
          failures++;
        end
        if (got.index_by_row != want.index_by_row) begin
          $error("index_by_row expected %0d got %0d", want.index_by_row,
                 got.index_by_row);
          failures++;
        end
        if (got.last != want.last) begin
          $error("last expected %0d got %0d", want.last, got.last);
          failures++;
        end
      end
      if (got.event_kind == KIND_UP) begin
        ups_seen++;
      end else begin
        downs_seen++;
      end
    end
  end

  // Stop the run when no request moves on any channel for too long
  always @(posedge clk_i) begin
    if ((scan_if.valid && scan_if.ready) || (event_if.valid && event_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    scan_if.valid  = 1'b0;
    scan_if.req    = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.req     = '0;
    held_keys      = '0;
    col_lines      = LIST_RESET;
    row_lines      = LIST_RESET;
    failures       = 0;
    scans_sent     = 0;
    list_writes    = 0;
    downs_seen     = 0;
    ups_seen       = 0;
    idle_cycles    = 0;
    gaps_on        = 1'b1;
    stall_on       = 1'b1;
    hold_req       = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_scans();
    test_line_lists();
    test_steady_traffic();
    test_backpressure();
    test_random_scans();
    wait_idle();

    $display("Sent %0d scans with %0d line list writes across extreme and random lists",
             scans_sent, list_writes);
    $display("Checked %0d key down and %0d key up events under stalls and a long hold",
             downs_seen, ups_seen);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
